@@ src/radix_digit_formatter_macros.svh @@
// assertion macros for the radix digit formatter
// used by the top level only, expects clk_i and rst_ni in scope
`ifndef RADIX_DIGIT_FORMATTER_MACROS_SVH
`define RADIX_DIGIT_FORMATTER_MACROS_SVH

// same-cycle implication
`define RDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rdf_pkg.sv @@
// shared types and constants of the radix digit formatter
// no dependencies
`timescale 1ns / 1ps

package rdf_pkg;

  localparam int unsigned NUM_CHARS = 16;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic [1:0] REG_RADIX      = 2'd0;
  localparam logic [1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [1:0] REG_CHARS_HIGH = 2'd2;

  typedef struct packed {
    logic [4:0]                     radix;
    logic [NUM_CHARS-1:0][7:0]      chars;
  } rdf_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT,
    ST_ERR
  } rdf_state_e;

endpackage

@@ src/radix_digit_formatter.sv @@
// radix digit formatter: an item of D digits is popped from the queue once the back end is
// idle, then divided digit by digit (eight quotient bits a cycle)
// after the last division step the digits are read from the store, msb first, and D words
// leave at one per cycle while the output is not stalled; the next item is popped only once
// every digit of the current one has been read; a rejected alphabet gives one error word
// a two-entry queue lets the next input be taken while the current one is converted
// reset clears config registers to zero and empties queue and pipeline; the digit store
// has no reset as every digit is written before it is read
`timescale 1ns / 1ps

`include "radix_digit_formatter_macros.svh"

module radix_digit_formatter import rdf_pkg::*; #(
  parameter int unsigned MAX_RADIX  = 16,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  // input word
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] in_value_i,
  // output word
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_character_o,
  output logic        out_final_char_o,
  output logic        out_alphabet_invalid_o
);

  // configuration registers
  logic [4:0]  radix_q;
  logic [63:0] chars_lo_q;
  logic [63:0] chars_hi_q;
  rdf_cfg_t    cfg;

  // front to queue, queue to back
  logic                q_full, push, q_valid, pop;
  logic [VALUE_BITS:0] push_data, q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= 5'd0;
      chars_lo_q <= 64'd0;
      chars_hi_q <= 64'd0;
    end else if (cfg_we_i) begin
      // unknown indices fall through and are ignored
      case (cfg_idx_i)
        REG_RADIX:      radix_q    <= cfg_wdata_i[4:0];
        REG_CHARS_LOW:  chars_lo_q <= cfg_wdata_i;
        REG_CHARS_HIGH: chars_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // character k sits in byte k of the joined alphabet
  assign cfg.radix = radix_q;
  assign cfg.chars = {chars_hi_q, chars_lo_q};

  // front: alphabet check and error tagging
  rdf_front #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_value_i  (in_value_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decoupling queue
  rdf_queue #(
    .DW (VALUE_BITS + 1)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  // back: division, digit store and output register
  rdf_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_i                  (cfg),
    .q_valid_i              (q_valid),
    .q_data_i               (q_data),
    .pop_o                  (pop),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_character_o        (out_character_o),
    .out_final_char_o       (out_final_char_o),
    .out_alphabet_invalid_o (out_alphabet_invalid_o)
  );

  // checks
  `RDF_ASSERT_NOW(a_err_word, out_valid_o && out_alphabet_invalid_o, out_final_char_o && (out_character_o == 8'd0), "error word must be final with zero character")
  `RDF_ASSERT_NOW(a_pop_valid, pop, q_valid, "back end popped an empty queue")
  `RDF_ASSERT_NEXT(a_full_hold, q_full && !pop, q_full, "queue lost an entry without a pop")

endmodule

@@ src/rdf_front.sv @@
// front end: takes input words, checks the alphabet and tags each word
// depends on rdf_pkg
`timescale 1ns / 1ps

module rdf_front import rdf_pkg::*; #(
  parameter int unsigned MAX_RADIX  = 16,
  parameter int unsigned VALUE_BITS = 64
) (
  input  rdf_cfg_t              cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [63:0]           in_value_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output logic [VALUE_BITS:0]   push_data_o
);

  logic bad;

  always_comb begin
    bad = (cfg_i.radix < 5'd2) || (cfg_i.radix > 5'(MAX_RADIX));
    for (int i = 0; i < NUM_CHARS; i++) begin
      if (5'(i) < cfg_i.radix) begin
        if (cfg_i.chars[i] == CHAR_PLUS || cfg_i.chars[i] == CHAR_MINUS) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < NUM_CHARS; j++) begin
          if (5'(j) < cfg_i.radix && cfg_i.chars[j] == cfg_i.chars[i]) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  assign in_stall_o  = q_full_i;
  assign push_o      = in_valid_i && !q_full_i;
  // error tag on top, masked value below
  assign push_data_o = {bad, in_value_i[VALUE_BITS-1:0]};

endmodule

@@ src/rdf_queue.sv @@
// two-entry queue between front and back end
// no dependencies
`timescale 1ns / 1ps

module rdf_queue #(
  parameter int unsigned DW = 65
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] data_o
);

  logic [DW-1:0] mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/rdf_back.sv @@
// back end: digit-serial division into a digit store, then msb-first output
// depends on rdf_pkg
`timescale 1ns / 1ps

module rdf_back import rdf_pkg::*; #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rdf_cfg_t            cfg_i,
  input  logic                q_valid_i,
  input  logic [VALUE_BITS:0] q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_character_o,
  output logic                out_final_char_o,
  output logic                out_alphabet_invalid_o
);

  localparam int unsigned CYC = (VALUE_BITS + 7) / 8;
  localparam int unsigned W   = CYC * 8;
  localparam int unsigned SW  = (CYC > 1) ? $clog2(CYC) : 1;
  localparam int unsigned AW  = $clog2(VALUE_BITS);
  localparam int unsigned CW  = $clog2(VALUE_BITS + 1);

  rdf_state_e state_q, state_d;

  logic [W-1:0]  work_q, work_d;
  logic [3:0]    rem_q, rem_d;
  logic [SW-1:0] stp_q, stp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;

  logic [3:0]    dig_mem [VALUE_BITS];
  logic [3:0]    mem_dq;
  logic          mem_v_q, mem_v_d;
  logic          mem_last_q, mem_last_d;

  logic          out_v_q, out_v_d;
  logic [7:0]    out_char_q, out_char_d;
  logic          out_fin_q, out_fin_d;
  logic          out_inv_q, out_inv_d;

  logic          out_free, moving, last_step;
  logic          wr_en, rd_en;
  logic [7:0]    qbits;
  logic [3:0]    rem_n;
  logic [W-1:0]  work_n;

  assign out_free  = !out_v_q || !out_stall_i;
  assign moving    = mem_v_q && out_free;
  assign last_step = (stp_q == SW'(CYC - 1));

  // eight restoring steps on the narrow remainder
  always_comb begin
    logic [4:0] t;
    logic [7:0] chunk;
    chunk = work_q[W-1 -: 8];
    t     = 5'd0;
    rem_n = rem_q;
    qbits = 8'd0;
    for (int b = 7; b >= 0; b--) begin
      t = {rem_n, chunk[b]};
      if (t >= cfg_i.radix) begin
        t        = t - cfg_i.radix;
        qbits[b] = 1'b1;
      end
      rem_n = t[3:0];
    end
    work_n = (work_q << 8) | W'(qbits);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = q_data_i[VALUE_BITS] ? ST_ERR : ST_DIV;
        end
      end
      ST_DIV: begin
        if (last_step && work_n == '0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if ((!mem_v_q || moving) && rd_idx_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (!mem_v_q && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop_o      = 1'b0;
    work_d     = work_q;
    rem_d      = rem_q;
    stp_d      = stp_q;
    cnt_d      = cnt_q;
    rd_idx_d   = rd_idx_q;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    mem_v_d    = mem_v_q && !moving;
    mem_last_d = mem_last_q;
    out_v_d    = out_v_q && out_stall_i;
    out_char_d = out_char_q;
    out_fin_d  = out_fin_q;
    out_inv_d  = out_inv_q;

    if (moving) begin
      out_v_d    = 1'b1;
      out_char_d = cfg_i.chars[mem_dq];
      out_fin_d  = mem_last_q;
      out_inv_d  = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        pop_o  = q_valid_i;
        work_d = W'(q_data_i[VALUE_BITS-1:0]);
        rem_d  = 4'd0;
        stp_d  = '0;
        cnt_d  = '0;
      end
      ST_DIV: begin
        work_d = work_n;
        rem_d  = rem_n;
        stp_d  = stp_q + SW'(1);
        if (last_step) begin
          wr_en    = 1'b1;
          cnt_d    = cnt_q + CW'(1);
          rd_idx_d = cnt_q[AW-1:0];
          rem_d    = 4'd0;
          stp_d    = '0;
        end
      end
      ST_EMIT: begin
        if (!mem_v_q || moving) begin
          rd_en      = 1'b1;
          mem_v_d    = 1'b1;
          mem_last_d = (rd_idx_q == '0);
          rd_idx_d   = rd_idx_q - AW'(1);
        end
      end
      ST_ERR: begin
        if (!mem_v_q && out_free) begin
          out_v_d    = 1'b1;
          out_char_d = 8'd0;
          out_fin_d  = 1'b1;
          out_inv_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mem_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mem_v_q <= mem_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    rem_q      <= rem_d;
    stp_q      <= stp_d;
    cnt_q      <= cnt_d;
    rd_idx_q   <= rd_idx_d;
    mem_last_q <= mem_last_d;
    out_char_q <= out_char_d;
    out_fin_q  <= out_fin_d;
    out_inv_q  <= out_inv_d;
  end

  // digit store, lsb digit at address zero
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dig_mem[cnt_q[AW-1:0]] <= rem_n;
    end
    if (rd_en) begin
      mem_dq <= dig_mem[rd_idx_q];
    end
  end

  assign out_valid_o            = out_v_q;
  assign out_character_o        = out_char_q;
  assign out_final_char_o       = out_fin_q;
  assign out_alphabet_invalid_o = out_inv_q;

endmodule
